@@ src/shift_chain_word_debouncer_core_macros.svh @@
`ifndef SHIFT_CHAIN_WORD_DEBOUNCER_CORE_MACROS_SVH
`define SHIFT_CHAIN_WORD_DEBOUNCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SDEB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");
`define SDEB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");
`else
`define SDEB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDEB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/sdeb_pkg.sv @@
package sdeb_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [COUNT_W-1:0] THR_RESET = 8'd4;

    localparam logic [1:0] FUNC_DEBOUNCE = 2'd0;
    localparam logic [1:0] FUNC_PRIME    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0]  committed;
        logic [WORD_W-1:0]  candidate;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic   wr;
        logic   hit;
        t_entry data;
    } t_upd;

    // Within every byte the four bit pairs are reversed in order.
    function automatic logic [WORD_W-1:0] descramble(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int p = 0; p < WORD_W / 2; p++) begin
            r[(p / 4) * 8 + (3 - (p % 4)) * 2 +: 2] = w[p * 2 +: 2];
        end
        return r;
    endfunction

endpackage

@@ src/shift_chain_word_debouncer_core.sv @@
// Shift-chain word debouncer.
// A word is offered on i_func, i_port_index, i_module_index and i_raw_word
// with start high; it is taken at a clock edge where busy is low. The word is
// descrambled and run through a per-(port, module) debounce entry held in a
// single RAM. Func 0 debounces, func 1 primes an entry, func 2 clears it.
// A commit under func 0 gives one result on the o_changed_* and o_*_word
// ports, marked by o_strobe for exactly one cycle, after the stage-1 and
// output registers. The receiver cannot stall, so results are never held back.
// One word can be taken every clock cycle while busy is low: the entry RAM is
// read on accept and written in the next cycle, and a back-to-back word to the
// same entry takes the freshly written entry from a bypass register. The
// threshold is written through i_debounce_samples_we and i_debounce_samples;
// the user must do this only while the block is idle; it is not enforced.
// Reset clears every entry at once through per-entry valid bits, sets the
// threshold to four and holds busy high until r_ready is set after reset.
`include "shift_chain_word_debouncer_core_macros.svh"

module shift_chain_word_debouncer_core #(
    parameter int PORTS   = 4,
    parameter int MODULES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic [1:0]                    i_port_index,
    input  logic [2:0]                    i_module_index,
    input  logic [sdeb_pkg::WORD_W-1:0]   i_raw_word,
    input  logic                          i_debounce_samples_we,
    input  logic [sdeb_pkg::COUNT_W-1:0]  i_debounce_samples,
    output logic                          o_strobe,
    output logic [1:0]                    o_changed_port,
    output logic [2:0]                    o_changed_module,
    output logic [sdeb_pkg::WORD_W-1:0]   o_previous_word,
    output logic [sdeb_pkg::WORD_W-1:0]   o_new_word
);

    localparam int Entries = PORTS * MODULES;
    localparam int AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int EntryW  = $bits(sdeb_pkg::t_entry);

    logic                          accept;
    logic                          in_range;
    logic [AddrW-1:0]              in_idx;

    logic                          r_ready;
    logic [sdeb_pkg::COUNT_W-1:0]  r_thr;
    logic [Entries-1:0]            r_vld;

    logic                          r_s1_valid;
    logic [1:0]                    r_s1_func;
    logic [1:0]                    r_s1_port;
    logic [2:0]                    r_s1_mod;
    logic [sdeb_pkg::WORD_W-1:0]   r_s1_raw;
    logic [AddrW-1:0]              r_s1_idx;

    logic                          r_fwd_valid;
    logic [AddrW-1:0]              r_fwd_idx;
    sdeb_pkg::t_entry              r_fwd_data;

    logic                          r_strobe;
    logic [1:0]                    r_out_port;
    logic [2:0]                    r_out_mod;
    logic [sdeb_pkg::WORD_W-1:0]   r_out_prev;
    logic [sdeb_pkg::WORD_W-1:0]   r_out_new;

    logic [EntryW-1:0]             ram_rdata;
    sdeb_pkg::t_entry              old_entry;
    sdeb_pkg::t_upd                upd;
    logic                          wr_en;
    logic [sdeb_pkg::WORD_W-1:0]   s1_word;

    assign busy   = !r_ready;
    assign accept = start && !busy;

    always_comb begin
        in_range = (int'(i_port_index) < PORTS) && (int'(i_module_index) < MODULES);
        in_idx   = AddrW'(int'(i_port_index) * MODULES + int'(i_module_index));
    end

    sdeb_ram #(
        .WIDTH (EntryW),
        .DEPTH (Entries)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_idx),
        .i_wdata (upd.data),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        s1_word = sdeb_pkg::descramble(r_s1_raw);
        if (r_fwd_valid && (r_fwd_idx == r_s1_idx)) begin
            old_entry = r_fwd_data;
        end else if (r_vld[r_s1_idx]) begin
            old_entry = sdeb_pkg::t_entry'(ram_rdata);
        end else begin
            old_entry = '0;
        end
    end

    sdeb_update u_update (
        .i_func      (r_s1_func),
        .i_word      (s1_word),
        .i_threshold (r_thr),
        .i_old       (old_entry),
        .o_upd       (upd)
    );

    assign wr_en = r_s1_valid && upd.wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_thr       <= sdeb_pkg::THR_RESET;
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_debounce_samples_we) begin
                r_thr <= i_debounce_samples;
            end
            if (wr_en) begin
                r_vld[r_s1_idx] <= 1'b1;
            end
            r_s1_valid  <= accept && in_range;
            r_fwd_valid <= wr_en;
            r_strobe    <= r_s1_valid && upd.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func <= i_func;
            r_s1_port <= i_port_index;
            r_s1_mod  <= i_module_index;
            r_s1_raw  <= i_raw_word;
            r_s1_idx  <= in_idx;
        end
        r_fwd_idx  <= r_s1_idx;
        r_fwd_data <= upd.data;
        if (r_s1_valid && upd.hit) begin
            r_out_port <= r_s1_port;
            r_out_mod  <= r_s1_mod;
            r_out_prev <= old_entry.committed;
            r_out_new  <= s1_word;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_changed_port   = r_out_port;
    assign o_changed_module = r_out_mod;
    assign o_previous_word  = r_out_prev;
    assign o_new_word       = r_out_new;

    `SDEB_ASSERT_NXT(a_strobe_from_item, i_clk, i_rst_n, !r_s1_valid, !o_strobe)
    `SDEB_ASSERT_IMP(a_change_differs, i_clk, i_rst_n, o_strobe, o_previous_word != o_new_word)
    `SDEB_ASSERT_NXT(a_write_bypass, i_clk, i_rst_n, wr_en, r_fwd_valid && (r_fwd_idx == $past(r_s1_idx)))

endmodule

@@ src/sdeb_ram.sv @@
module sdeb_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sdeb_update.sv @@
module sdeb_update (
    input  logic [1:0]                        i_func,
    input  logic [sdeb_pkg::WORD_W-1:0]       i_word,
    input  logic [sdeb_pkg::COUNT_W-1:0]      i_threshold,
    input  sdeb_pkg::t_entry                  i_old,
    output sdeb_pkg::t_upd                    o_upd
);

    logic                         same;
    logic [sdeb_pkg::COUNT_W-1:0] cnt;

    always_comb begin
        same = (i_word == i_old.candidate);
        if (!same) begin
            cnt = sdeb_pkg::COUNT_W'(1);
        end else if (i_old.count == sdeb_pkg::COUNT_MAX) begin
            cnt = sdeb_pkg::COUNT_MAX;
        end else begin
            cnt = i_old.count + sdeb_pkg::COUNT_W'(1);
        end

        o_upd = '0;
        case (i_func)
            sdeb_pkg::FUNC_DEBOUNCE: begin
                o_upd.wr             = 1'b1;
                o_upd.hit            = (cnt >= i_threshold) && (i_old.committed != i_word);
                o_upd.data.candidate = i_word;
                o_upd.data.count     = cnt;
                o_upd.data.committed = o_upd.hit ? i_word : i_old.committed;
            end
            sdeb_pkg::FUNC_PRIME: begin
                o_upd.wr             = 1'b1;
                o_upd.data.candidate = i_word;
                o_upd.data.committed = i_word;
                o_upd.data.count     = i_threshold;
            end
            sdeb_pkg::FUNC_CLEAR: begin
                o_upd.wr = 1'b1;
            end
            default: begin
                o_upd.wr = 1'b0;
            end
        endcase
    end

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_PORTS   = 4;
    localparam int          NUM_MODULES = 8;
    localparam int          NUM_ENTRIES = NUM_PORTS * NUM_MODULES;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          SETTLE      = 6;
    localparam int          NUM_ROWS    = 16;

    typedef struct packed {
        logic [1:0]                  port;
        logic [2:0]                  mod_idx;
        logic [sdeb_pkg::WORD_W-1:0] prev_word;
        logic [sdeb_pkg::WORD_W-1:0] next_word;
    } t_change;

    typedef struct packed {
        logic [1:0]                  func;
        logic [1:0]                  port;
        logic [2:0]                  mod_idx;
        logic [sdeb_pkg::WORD_W-1:0] raw;
        logic                        typed;
        t_change                     want;
    } t_scan_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    i_func = sdeb_pkg::FUNC_DEBOUNCE;
    logic [1:0]                    i_port_index = 2'd0;
    logic [2:0]                    i_module_index = 3'd0;
    logic [sdeb_pkg::WORD_W-1:0]   i_raw_word = '0;
    logic                          i_debounce_samples_we = 1'b0;
    logic [sdeb_pkg::COUNT_W-1:0]  i_debounce_samples = '0;
    logic                          o_strobe;
    logic [1:0]                    o_changed_port;
    logic [2:0]                    o_changed_module;
    logic [sdeb_pkg::WORD_W-1:0]   o_previous_word;
    logic [sdeb_pkg::WORD_W-1:0]   o_new_word;

    logic                          row_typed = 1'b0;
    t_change                       row_want = '0;

    logic [sdeb_pkg::WORD_W-1:0]   held_word [NUM_ENTRIES];
    logic [sdeb_pkg::WORD_W-1:0]   cand_word [NUM_ENTRIES];
    logic [sdeb_pkg::COUNT_W-1:0]  run_len [NUM_ENTRIES];
    logic [sdeb_pkg::COUNT_W-1:0]  model_thr;
    t_change                       pending_changes [$];
    int                            fails = 0;
    int                            cycles = 0;
    int                            idle_pct = 0;
    int                            thr_now = 4;
    logic [sdeb_pkg::WORD_W-1:0]   raw_pool [6];
    t_scan_row                     directed [NUM_ROWS];

    shift_chain_word_debouncer_core #(
        .PORTS   (NUM_PORTS),
        .MODULES (NUM_MODULES)
    ) uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_func                (i_func),
        .i_port_index          (i_port_index),
        .i_module_index        (i_module_index),
        .i_raw_word            (i_raw_word),
        .i_debounce_samples_we (i_debounce_samples_we),
        .i_debounce_samples    (i_debounce_samples),
        .o_strobe              (o_strobe),
        .o_changed_port        (o_changed_port),
        .o_changed_module      (o_changed_module),
        .o_previous_word       (o_previous_word),
        .o_new_word            (o_new_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Reverses the order of the four bit pairs inside each byte.
    function automatic logic [sdeb_pkg::WORD_W-1:0] unshuffle_pairs(
        input logic [sdeb_pkg::WORD_W-1:0] w);
        logic [sdeb_pkg::WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < 4; b++) begin
            for (int k = 0; k < 4; k++) begin
                r[b * 8 + (3 - k) * 2 +: 2] = w[b * 8 + k * 2 +: 2];
            end
        end
        return r;
    endfunction

    function automatic bit debounce_step(input logic [1:0] func, input logic [1:0] port,
                                         input logic [2:0] mod_idx,
                                         input logic [sdeb_pkg::WORD_W-1:0] raw,
                                         output t_change chg);
        logic [sdeb_pkg::WORD_W-1:0] w;
        int                          e;
        w   = unshuffle_pairs(raw);
        e   = int'(port) * NUM_MODULES + int'(mod_idx);
        chg = '0;
        case (func)
            sdeb_pkg::FUNC_DEBOUNCE: begin
                if (w == cand_word[e]) begin
                    if (run_len[e] != sdeb_pkg::COUNT_MAX) run_len[e] = run_len[e] + 1'b1;
                end else begin
                    cand_word[e] = w;
                    run_len[e]   = 8'd1;
                end
                if (run_len[e] >= model_thr && held_word[e] != cand_word[e]) begin
                    chg.port      = port;
                    chg.mod_idx   = mod_idx;
                    chg.prev_word = held_word[e];
                    chg.next_word = cand_word[e];
                    held_word[e]  = cand_word[e];
                    return 1'b1;
                end
            end
            sdeb_pkg::FUNC_PRIME: begin
                held_word[e] = w;
                cand_word[e] = w;
                run_len[e]   = model_thr;
            end
            sdeb_pkg::FUNC_CLEAR: begin
                held_word[e] = '0;
                cand_word[e] = '0;
                run_len[e]   = '0;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_scan_row row(input logic [1:0] func, input logic [1:0] port,
                                      input logic [2:0] mod_idx,
                                      input logic [sdeb_pkg::WORD_W-1:0] raw,
                                      input logic typed,
                                      input logic [sdeb_pkg::WORD_W-1:0] prev_w,
                                      input logic [sdeb_pkg::WORD_W-1:0] next_w);
        t_scan_row s;
        s.func    = func;
        s.port    = port;
        s.mod_idx = mod_idx;
        s.raw     = raw;
        s.typed   = typed;
        s.want    = {port, mod_idx, prev_w, next_w};
        return s;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_change got;
        t_change exp_chg;
        t_change pred;
        bit      hit;
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                held_word[e] = '0;
                cand_word[e] = '0;
                run_len[e]   = '0;
            end
            model_thr = sdeb_pkg::THR_RESET;
            pending_changes.delete();
        end else begin
            if (o_strobe) begin
                got = {o_changed_port, o_changed_module, o_previous_word, o_new_word};
                if (pending_changes.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected change word: %h", got);
                end else begin
                    exp_chg = pending_changes.pop_front();
                    if (got.port != exp_chg.port || got.mod_idx != exp_chg.mod_idx ||
                        got.prev_word != exp_chg.prev_word ||
                        got.next_word != exp_chg.next_word) begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: expected port %0d module %0d prev %h new %h,",
                                      " got port %0d module %0d prev %h new %h"},
                                     exp_chg.port, exp_chg.mod_idx, exp_chg.prev_word,
                                     exp_chg.next_word, got.port, got.mod_idx,
                                     got.prev_word, got.next_word);
                    end
                end
            end
            if (i_debounce_samples_we) model_thr = i_debounce_samples;
            if (start && !busy) begin
                hit = debounce_step(i_func, i_port_index, i_module_index, i_raw_word, pred);
                if (row_typed) pending_changes.push_back(row_want);
                else if (hit) pending_changes.push_back(pred);
            end
        end
    end

    task automatic send_word(input logic [1:0] func, input logic [1:0] port,
                             input logic [2:0] mod_idx,
                             input logic [sdeb_pkg::WORD_W-1:0] raw,
                             input logic typed, input t_change want);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_port_index   <= port;
        i_module_index <= mod_idx;
        i_raw_word     <= raw;
        row_typed      <= typed;
        row_want       <= want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain;
        start <= 1'b0;
        do @(posedge i_clk); while (pending_changes.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [sdeb_pkg::COUNT_W-1:0] v);
        i_debounce_samples_we <= 1'b1;
        i_debounce_samples    <= v;
        @(posedge i_clk);
        i_debounce_samples_we <= 1'b0;
        @(posedge i_clk);
        thr_now = int'(v);
    endtask

    task automatic random_phase(input int budget);
        int                          sent;
        int                          r;
        int                          len;
        logic [1:0]                  p;
        logic [2:0]                  m;
        logic [sdeb_pkg::WORD_W-1:0] raw;
        sent = 0;
        while (sent < budget) begin
            p   = 2'($urandom_range(0, 3));
            m   = 3'($urandom_range(0, 7));
            raw = $urandom_range(0, 1) ? raw_pool[$urandom_range(0, 5)] : $urandom;
            r   = $urandom_range(0, 99);
            if (r < 8) begin
                send_word(sdeb_pkg::FUNC_PRIME, p, m, raw, 1'b0, '0);
                sent++;
            end else if (r < 13) begin
                send_word(sdeb_pkg::FUNC_CLEAR, p, m, raw, 1'b0, '0);
                sent++;
            end else if (r < 16) begin
                send_word(FUNC_UNUSED, p, m, $urandom, 1'b0, '0);
                sent++;
            end else begin
                if (thr_now > 8) len = thr_now + $urandom_range(0, 20);
                else len = $urandom_range(1, thr_now + 3);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 15) begin
                        send_word(sdeb_pkg::FUNC_DEBOUNCE, 2'($urandom_range(0, 3)),
                                  3'($urandom_range(0, 7)), $urandom, 1'b0, '0);
                        sent++;
                    end
                    send_word(sdeb_pkg::FUNC_DEBOUNCE, p, m, raw, 1'b0, '0);
                    sent++;
                end
            end
        end
        drain();
    endtask

    initial begin
        int thr_plan [6];
        int budget;
        directed[0]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd0, 3'd0, 32'h0000_0000, 1'b0, '0, '0);
        directed[1]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd0, 3'd0, 32'h0000_0003, 1'b0, '0, '0);
        directed[2]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd0, 3'd0, 32'h0000_0003, 1'b0, '0, '0);
        directed[3]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd0, 3'd0, 32'h0000_0003, 1'b0, '0, '0);
        directed[4]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd0, 3'd0, 32'h0000_0003, 1'b1,
                           32'h0000_0000, 32'h0000_00C0);
        directed[5]  = row(sdeb_pkg::FUNC_PRIME,    2'd3, 3'd7, 32'hFFFF_FFFF, 1'b0, '0, '0);
        directed[6]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd3, 3'd7, 32'h0000_0000, 1'b0, '0, '0);
        directed[7]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd3, 3'd7, 32'h0000_0000, 1'b0, '0, '0);
        directed[8]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd3, 3'd7, 32'h0000_0000, 1'b0, '0, '0);
        directed[9]  = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd3, 3'd7, 32'h0000_0000, 1'b1,
                           32'hFFFF_FFFF, 32'h0000_0000);
        directed[10] = row(sdeb_pkg::FUNC_CLEAR,    2'd0, 3'd0, 32'h5A5A_A5A5, 1'b0, '0, '0);
        directed[11] = row(FUNC_UNUSED,             2'd1, 3'd3, 32'hDEAD_BEEF, 1'b0, '0, '0);
        directed[12] = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd2, 3'd5, 32'hAAAA_AAAA, 1'b0, '0, '0);
        directed[13] = row(sdeb_pkg::FUNC_PRIME,    2'd2, 3'd5, 32'h1B1B_1B1B, 1'b0, '0, '0);
        directed[14] = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd2, 3'd5, 32'h1B1B_1B1B, 1'b0, '0, '0);
        directed[15] = row(sdeb_pkg::FUNC_DEBOUNCE, 2'd2, 3'd5, 32'hE4E4_E4E4, 1'b0, '0, '0);
        raw_pool[0] = 32'h0000_0000;
        raw_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++) raw_pool[i] = $urandom;
        thr_plan[0] = 1;
        thr_plan[1] = 0;
        thr_plan[2] = 255;
        thr_plan[3] = 2;
        thr_plan[4] = $urandom_range(9, 60);
        thr_plan[5] = 4;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            send_word(directed[i].func, directed[i].port, directed[i].mod_idx,
                      directed[i].raw, directed[i].typed, directed[i].want);
        end
        row_typed <= 1'b0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(8'(thr_plan[ph]));
            case (ph % 4)
                1:       idle_pct = 55;
                3:       idle_pct = 34;
                default: idle_pct = 0;
            endcase
            budget = (thr_plan[ph] == 255) ? 520 : 100;
            random_phase(budget);
        end

        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/sdeb_pkg.sv
src/sdeb_ram.sv
src/sdeb_update.sv
src/shift_chain_word_debouncer_core.sv
tb/tb.sv
